### src/lpf_pkg.sv
// Package for the Lennard-Jones pair force pipeline: constants, codes and item types.
`default_nettype none
package lpf_pkg;

  // Sizes
  localparam int NUM_KINDS  = 2;
  localparam int POS_WIDTH  = 32;
  localparam int KIND_W     = 1;
  localparam int WGT_W      = 16;
  localparam int COEF_W     = 48;
  localparam int OUT_W      = 48;
  localparam int DM_W       = POS_WIDTH + 1;
  localparam int SQ_W       = 2 * DM_W;
  localparam int RSQ_W      = SQ_W + 2;
  localparam int Q_W        = 64;
  localparam int DIV_STAGES = Q_W;
  localparam int LANES      = 3;
  localparam int NUM_REGS   = 8;
  localparam int COEF_PAIRS = 4;
  localparam int CFG_IDX_W  = 4;

  // ceil(2^48 / 3): x * RECIP3 / 2^48 is exactly floor(x / 3) for x below 2^47.
  // The multiplier drops 32 bits, the remaining shift is RECIP3_SH.
  localparam logic [Q_W-1:0] RECIP3    = 64'h0000_5555_5555_5556;
  localparam int             RECIP3_SH = 16;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Multiplier shift selections
  localparam logic [1:0] SH_32 = 2'd0;
  localparam logic [1:0] SH_28 = 2'd1;
  localparam logic [1:0] SH_16 = 2'd2;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] pos_ax;
    logic signed [POS_WIDTH-1:0] pos_ay;
    logic signed [POS_WIDTH-1:0] pos_az;
    logic signed [POS_WIDTH-1:0] pos_bx;
    logic signed [POS_WIDTH-1:0] pos_by;
    logic signed [POS_WIDTH-1:0] pos_bz;
    logic [KIND_W-1:0]           kind_a;
    logic [KIND_W-1:0]           kind_b;
    logic [WGT_W-1:0]            weight_a;
    logic [WGT_W-1:0]            weight_b;
    logic                        want_energy;
  } pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] pair_energy;
    logic [1:0]              status;
  } result_t;

  // Sideband that travels with an item down the whole pipeline
  typedef struct packed {
    logic [LANES-1:0][DM_W-1:0] dm;
    logic [LANES-1:0]           dneg;
    logic [2*WGT_W-1:0]         w;
    logic                       want_e;
    logic                       zero;
    logic                       sat;
    logic [COEF_W-1:0]          a;
    logic [COEF_W-1:0]          b;
    logic [Q_W-1:0]             a12;
    logic [Q_W-1:0]             b6;
    logic [Q_W-1:0]             r2;
    logic [Q_W-1:0]             r6;
    logic                       fneg;
    logic                       eneg;
    logic [Q_W-1:0]             emag;
  } side_t;

  // Types above the top kind fold onto the top kind
  function automatic logic [KIND_W-1:0] kind_clamp(logic [KIND_W-1:0] k);
    if (int'(k) >= NUM_KINDS) return KIND_W'(NUM_KINDS - 1);
    return k;
  endfunction

endpackage
`default_nettype wire

### src/lpf_prep.sv
// Front end: displacement, magnitudes, squares and r^2 sum, plus coefficient pick.
`default_nettype none
module lpf_prep import lpf_pkg::*; (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               vld_in,
  input  wire pair_t                              pair_in,
  input  wire logic [COEF_PAIRS-1:0][COEF_W-1:0]  coef_a,
  input  wire logic [COEF_PAIRS-1:0][COEF_W-1:0]  coef_b,
  output logic                                    vld_out,
  output logic [RSQ_W-1:0]                        rsq,
  output side_t                                   side_out
);

  logic [3:0] vld;
  logic signed [LANES-1:0][DM_W-1:0] d1;
  side_t s1, s2, s3;
  side_t s1_next, s2_next;
  logic [LANES-1:0][SQ_W-1:0] sq3;

  logic [1:0] cidx;
  assign cidx = {kind_clamp(pair_in.kind_a), kind_clamp(pair_in.kind_b)};

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], vld_in};
    end
  end

  // Sideband for stage 1: weight product and coefficients
  always_comb begin
    s1_next        = '0;
    s1_next.w      = (2*WGT_W)'(pair_in.weight_a) * (2*WGT_W)'(pair_in.weight_b);
    s1_next.want_e = pair_in.want_energy;
    s1_next.a      = coef_a[cidx];
    s1_next.b      = coef_b[cidx];
  end

  // Stage 1: differences, weight product, coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DM_W'({pair_in.pos_ax[POS_WIDTH-1], pair_in.pos_ax}
                   - {pair_in.pos_bx[POS_WIDTH-1], pair_in.pos_bx});
      d1[1] <= DM_W'({pair_in.pos_ay[POS_WIDTH-1], pair_in.pos_ay}
                   - {pair_in.pos_by[POS_WIDTH-1], pair_in.pos_by});
      d1[2] <= DM_W'({pair_in.pos_az[POS_WIDTH-1], pair_in.pos_az}
                   - {pair_in.pos_bz[POS_WIDTH-1], pair_in.pos_bz});
      s1    <= s1_next;
    end
  end

  // Magnitudes and signs
  always_comb begin
    s2_next = s1;
    for (int i = 0; i < LANES; i++) begin
      s2_next.dneg[i] = d1[i][DM_W-1];
      s2_next.dm[i]   = d1[i][DM_W-1] ? DM_W'(-d1[i]) : DM_W'(d1[i]);
    end
  end

  // Stage 2: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s2;
      for (int i = 0; i < LANES; i++) begin
        sq3[i] <= SQ_W'(s2.dm[i]) * SQ_W'(s2.dm[i]);
      end
    end
  end

  // Stage 4: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= s3;
      rsq      <= RSQ_W'(sq3[0]) + RSQ_W'(sq3[1]) + RSQ_W'(sq3[2]);
    end
  end

  assign vld_out = vld[3];

endmodule
`default_nettype wire

### src/lpf_div.sv
// Restoring divider, one quotient bit per stage: r^-2 = 2^64 / r^2.
`default_nettype none
module lpf_div import lpf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire logic [RSQ_W-1:0]  rsq,
  input  wire side_t             side_in,
  output logic                   vld_out,
  output side_t                  side_out
);

  logic [DIV_STAGES-1:0] vld;
  side_t            sd  [DIV_STAGES];
  logic [RSQ_W-1:0] dv  [DIV_STAGES];
  logic [RSQ_W-1:0] rem [DIV_STAGES];
  logic [Q_W-1:0]   quo [DIV_STAGES];

  side_t            sd_next  [DIV_STAGES];
  logic [RSQ_W-1:0] dv_next  [DIV_STAGES];
  logic [RSQ_W-1:0] rem_next [DIV_STAGES];
  logic [Q_W-1:0]   quo_next [DIV_STAGES];

  // One quotient bit per stage; bit 64 of the dividend is consumed at entry
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      logic [RSQ_W-1:0] r_src, d_src;
      logic [Q_W-1:0]   q_src;
      logic [RSQ_W:0]   t;
      if (k == 0) begin
        sd_next[k]      = side_in;
        sd_next[k].zero = (rsq == '0);
        sd_next[k].sat  = side_in.sat | (rsq == RSQ_W'(1));
        d_src  = rsq;
        r_src  = RSQ_W'(1);
        q_src  = '0;
      end else begin
        sd_next[k] = sd[k-1];
        d_src  = dv[k-1];
        r_src  = rem[k-1];
        q_src  = quo[k-1];
      end
      dv_next[k] = d_src;
      t = {r_src, 1'b0};
      if (t >= {1'b0, d_src}) begin
        rem_next[k] = RSQ_W'(t - {1'b0, d_src});
        quo_next[k] = {q_src[Q_W-2:0], 1'b1};
      end else begin
        rem_next[k] = RSQ_W'(t);
        quo_next[k] = {q_src[Q_W-2:0], 1'b0};
      end
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], vld_in};
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        sd[k]  <= sd_next[k];
        dv[k]  <= dv_next[k];
        rem[k] <= rem_next[k];
        quo[k] <= quo_next[k];
      end
    end
  end

  // At this point sat is set only by a one-LSB r^2, which forces r^-2 to full scale
  always_comb begin
    side_out     = sd[DIV_STAGES-1];
    side_out.r2  = sd[DIV_STAGES-1].sat ? '1 : quo[DIV_STAGES-1];
  end

  assign vld_out = vld[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/lpf_mul.sv
// Three-lane 64x64 multiplier in four stages with shift and saturation to 64 bits.
`default_nettype none
module lpf_mul import lpf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       vld_in,
  input  wire side_t                      side_in,
  input  wire logic [1:0]                 shift_sel,
  input  wire logic [LANES-1:0][Q_W-1:0]  op_a,
  input  wire logic [LANES-1:0][Q_W-1:0]  op_b,
  output logic                            vld_out,
  output side_t                           side_out,
  output logic [LANES-1:0][Q_W-1:0]       res,
  output logic [LANES-1:0]                sat
);

  logic [3:0] vld;
  side_t s1, s2, s3;
  logic [LANES-1:0][3:0][Q_W-1:0] pp;
  logic [LANES-1:0][Q_W-1:0]      lo2, hi2;
  logic [LANES-1:0][Q_W:0]        mid2;
  logic [LANES-1:0][2*Q_W-1:0]    full3;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], vld_in};
    end
  end

  // Stage 1: 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= side_in;
      for (int l = 0; l < LANES; l++) begin
        pp[l][0] <= Q_W'(op_a[l][31:0])  * Q_W'(op_b[l][31:0]);
        pp[l][1] <= Q_W'(op_a[l][31:0])  * Q_W'(op_b[l][63:32]);
        pp[l][2] <= Q_W'(op_a[l][63:32]) * Q_W'(op_b[l][31:0]);
        pp[l][3] <= Q_W'(op_a[l][63:32]) * Q_W'(op_b[l][63:32]);
      end
    end
  end

  // Stage 2: cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      for (int l = 0; l < LANES; l++) begin
        lo2[l]  <= pp[l][0];
        hi2[l]  <= pp[l][3];
        mid2[l] <= (Q_W+1)'(pp[l][1]) + (Q_W+1)'(pp[l][2]);
      end
    end
  end

  // Stage 3: full product
  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s2;
      for (int l = 0; l < LANES; l++) begin
        full3[l] <= {hi2[l], lo2[l]} + {31'b0, mid2[l], 32'b0};
      end
    end
  end

  // Stage 4: shift and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= s3;
      for (int l = 0; l < LANES; l++) begin
        unique case (shift_sel)
          SH_28: begin
            sat[l] <= |full3[l][127:92];
            res[l] <= (|full3[l][127:92]) ? '1 : full3[l][91:28];
          end
          SH_16: begin
            sat[l] <= |full3[l][127:80];
            res[l] <= (|full3[l][127:80]) ? '1 : full3[l][79:16];
          end
          default: begin
            sat[l] <= |full3[l][127:96];
            res[l] <= (|full3[l][127:96]) ? '1 : full3[l][95:32];
          end
        endcase
      end
    end
  end

  assign vld_out = vld[3];

endmodule
`default_nettype wire

### src/lj_pair_force_core.sv
// Top level of the Lennard-Jones 12-6 pair force pipeline.
// One atom pair item enters per clock unless stalled, and its result item passes
// through 4 front-end stages, 64 divider stages producing r^-2 one quotient bit
// each, seven 4-stage multiplier passes, the first of which also forms A/12 and
// B/6 by reciprocal multiplication, one subtract stage and one output register.
// The whole pipeline advances together and halts only while a finished result is
// held stalled at the output; pair_stall then follows res_stall. The eight
// coefficient registers are written through the cfg port, which is always ready;
// write them only while no item is in flight.
`default_nettype none
module lj_pair_force_core import lpf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pair_valid,
  output logic                      pair_stall,
  input  wire pair_t                pair_data,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output result_t                   res_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  localparam logic [Q_W-1:0] OUT_POS_MAX = (Q_W'(1) << (OUT_W - 1)) - Q_W'(1);
  localparam logic [Q_W-1:0] OUT_NEG_MAX = Q_W'(1) << (OUT_W - 1);

  logic en;
  logic [COEF_PAIRS-1:0][COEF_W-1:0] coef_a, coef_b;

  // Global advance: everything moves unless the output is held
  assign en         = !(res_valid && res_stall);
  assign pair_stall = !en;
  assign cfg_ready  = 1'b1;

  // Coefficient registers; even index is A, odd is B
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
    end else if (cfg_valid && (int'(cfg_index) < NUM_REGS)) begin
      if (cfg_index[0]) coef_b[cfg_index[2:1]] <= cfg_data;
      else              coef_a[cfg_index[2:1]] <= cfg_data;
    end
  end

  // Front end and divider
  logic              prep_vld, div_vld;
  logic [RSQ_W-1:0]  prep_rsq;
  side_t             prep_side, div_side;

  lpf_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .vld_in(pair_valid), .pair_in(pair_data),
    .coef_a(coef_a), .coef_b(coef_b),
    .vld_out(prep_vld), .rsq(prep_rsq), .side_out(prep_side)
  );

  lpf_div u_div (
    .clk(clk), .rst(rst), .en(en), .vld_in(prep_vld), .rsq(prep_rsq),
    .side_in(prep_side), .vld_out(div_vld), .side_out(div_side)
  );

  // Multiplier passes
  logic m1_vld, m2_vld, m3_vld, m4_vld, m5_vld, m6_vld, m7_vld;
  side_t m1_side, m2_side, m3_side, m4_side, m5_side, m6_side, m7_side;
  side_t m2_in, m4_in, m5_in, m6_in, m7_in;
  logic [LANES-1:0][Q_W-1:0] m1_res, m2_res, m3_res, m4_res, m5_res, m6_res, m7_res;
  logic [LANES-1:0][Q_W-1:0] m1_a, m1_b, m2_a, m2_b, m3_a, m3_b, m4_a, m4_b;
  logic [LANES-1:0][Q_W-1:0] m5_a, m5_b, m6_a, m6_b, m7_a, m7_b;
  logic [LANES-1:0] m1_sat, m2_sat, m3_sat, m4_sat, m5_sat, m6_sat, m7_sat;

  // Subtract stage between A*r6 and the second r6 multiply
  logic          sub_vld;
  side_t         sub_side, sub_side_next;
  logic [Q_W-1:0] sub_tm, sub_tem, sub_tm_next, sub_tem_next;

  // r^-4 = r2 * r2; lanes 1 and 2 form (A/4)/3 and (B/2)/3 by reciprocal
  always_comb begin
    m1_a = '0;
    m1_b = '0;
    m1_a[0] = div_side.r2;
    m1_b[0] = div_side.r2;
    m1_a[1] = Q_W'(div_side.a >> 2);
    m1_b[1] = RECIP3;
    m1_a[2] = Q_W'(div_side.b >> 1);
    m1_b[2] = RECIP3;
  end

  lpf_mul u_m1 (
    .clk(clk), .rst(rst), .en(en), .vld_in(div_vld), .side_in(div_side),
    .shift_sel(SH_32), .op_a(m1_a), .op_b(m1_b),
    .vld_out(m1_vld), .side_out(m1_side), .res(m1_res), .sat(m1_sat)
  );

  // r^-6 = r^-4 * r2; the reciprocal lanes cannot overflow
  always_comb begin
    m2_in     = m1_side;
    m2_in.sat = m1_side.sat | m1_sat[0];
    m2_in.a12 = m1_res[1] >> RECIP3_SH;
    m2_in.b6  = m1_res[2] >> RECIP3_SH;
    m2_a = '0;
    m2_b = '0;
    m2_a[0] = m1_res[0];
    m2_b[0] = m1_side.r2;
  end

  lpf_mul u_m2 (
    .clk(clk), .rst(rst), .en(en), .vld_in(m1_vld), .side_in(m2_in),
    .shift_sel(SH_32), .op_a(m2_a), .op_b(m2_b),
    .vld_out(m2_vld), .side_out(m2_side), .res(m2_res), .sat(m2_sat)
  );

  // A*r6 for the force, A/12*r6 for the energy
  side_t m3_in;
  always_comb begin
    m3_in     = m2_side;
    m3_in.sat = m2_side.sat | m2_sat[0];
    m3_in.r6  = m2_res[0];
    m3_a = '0;
    m3_b = '0;
    m3_a[0] = Q_W'(m2_side.a);
    m3_b[0] = m2_res[0];
    m3_a[1] = m2_side.a12;
    m3_b[1] = m2_res[0];
  end

  lpf_mul u_m3 (
    .clk(clk), .rst(rst), .en(en), .vld_in(m2_vld), .side_in(m3_in),
    .shift_sel(SH_32), .op_a(m3_a), .op_b(m3_b),
    .vld_out(m3_vld), .side_out(m3_side), .res(m3_res), .sat(m3_sat)
  );

  // Signed differences against B and B/6, kept as magnitude and sign
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_vld <= 1'b0;
    end else if (en) begin
      sub_vld <= m3_vld;
    end
  end

  always_comb begin
    sub_side_next     = m3_side;
    sub_side_next.sat = m3_side.sat | m3_sat[0] | (m3_side.want_e & m3_sat[1]);
    if (m3_res[0] >= Q_W'(m3_side.b)) begin
      sub_tm_next        = m3_res[0] - Q_W'(m3_side.b);
      sub_side_next.fneg = 1'b0;
    end else begin
      sub_tm_next        = Q_W'(m3_side.b) - m3_res[0];
      sub_side_next.fneg = 1'b1;
    end
    if (m3_res[1] >= m3_side.b6) begin
      sub_tem_next       = m3_res[1] - m3_side.b6;
      sub_side_next.eneg = 1'b0;
    end else begin
      sub_tem_next       = m3_side.b6 - m3_res[1];
      sub_side_next.eneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sub_side <= sub_side_next;
      sub_tm   <= sub_tm_next;
      sub_tem  <= sub_tem_next;
    end
  end

  // r6 * |t| for force and energy
  always_comb begin
    m4_in = sub_side;
    m4_a = '0;
    m4_b = '0;
    m4_a[0] = sub_side.r6;
    m4_b[0] = sub_tm;
    m4_a[1] = sub_side.r6;
    m4_b[1] = sub_tem;
  end

  lpf_mul u_m4 (
    .clk(clk), .rst(rst), .en(en), .vld_in(sub_vld), .side_in(m4_in),
    .shift_sel(SH_32), .op_a(m4_a), .op_b(m4_b),
    .vld_out(m4_vld), .side_out(m4_side), .res(m4_res), .sat(m4_sat)
  );

  // times r^-2
  always_comb begin
    m5_in      = m4_side;
    m5_in.sat  = m4_side.sat | m4_sat[0] | (m4_side.want_e & m4_sat[1]);
    m5_in.emag = m4_res[1];
    m5_a = '0;
    m5_b = '0;
    m5_a[0] = m4_res[0];
    m5_b[0] = m4_side.r2;
  end

  lpf_mul u_m5 (
    .clk(clk), .rst(rst), .en(en), .vld_in(m4_vld), .side_in(m5_in),
    .shift_sel(SH_32), .op_a(m5_a), .op_b(m5_b),
    .vld_out(m5_vld), .side_out(m5_side), .res(m5_res), .sat(m5_sat)
  );

  // times the weight product, Q4.28
  always_comb begin
    m6_in     = m5_side;
    m6_in.sat = m5_side.sat | m5_sat[0];
    m6_a = '0;
    m6_b = '0;
    m6_a[0] = m5_res[0];
    m6_b[0] = Q_W'(m5_side.w);
  end

  lpf_mul u_m6 (
    .clk(clk), .rst(rst), .en(en), .vld_in(m5_vld), .side_in(m6_in),
    .shift_sel(SH_28), .op_a(m6_a), .op_b(m6_b),
    .vld_out(m6_vld), .side_out(m6_side), .res(m6_res), .sat(m6_sat)
  );

  // times each displacement magnitude
  always_comb begin
    m7_in     = m6_side;
    m7_in.sat = m6_side.sat | m6_sat[0];
    for (int l = 0; l < LANES; l++) begin
      m7_a[l] = m6_res[0];
      m7_b[l] = Q_W'(m6_side.dm[l]);
    end
  end

  lpf_mul u_m7 (
    .clk(clk), .rst(rst), .en(en), .vld_in(m6_vld), .side_in(m7_in),
    .shift_sel(SH_16), .op_a(m7_a), .op_b(m7_b),
    .vld_out(m7_vld), .side_out(m7_side), .res(m7_res), .sat(m7_sat)
  );

  // Clamp a magnitude to the signed output range; top bit flags a clamp
  function automatic logic [OUT_W:0] to_out(logic [Q_W-1:0] mag, logic neg);
    logic [Q_W-1:0] m;
    logic           s;
    m = mag;
    s = 1'b0;
    if (neg) begin
      if (mag > OUT_NEG_MAX) begin
        m = OUT_NEG_MAX;
        s = 1'b1;
      end
      m = ~m + Q_W'(1);
    end else if (mag > OUT_POS_MAX) begin
      m = OUT_POS_MAX;
      s = 1'b1;
    end
    return {s, m[OUT_W-1:0]};
  endfunction

  // Output formatting
  logic [LANES-1:0][OUT_W:0] fo;
  logic [OUT_W:0]            eo;
  logic                      sat_all;
  result_t                   res_data_next;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fo[l] = to_out(m7_res[l], m7_side.fneg ^ m7_side.dneg[l]);
    end
    eo = to_out(m7_side.emag, m7_side.eneg);
    sat_all = m7_side.sat | (|m7_sat) | fo[0][OUT_W] | fo[1][OUT_W] | fo[2][OUT_W]
            | (m7_side.want_e & eo[OUT_W]);
  end

  // Zero distance gives all-zero outputs
  always_comb begin
    res_data_next = '0;
    if (m7_side.zero) begin
      res_data_next.status = ST_ZERO;
    end else begin
      res_data_next.force_x     = fo[0][OUT_W-1:0];
      res_data_next.force_y     = fo[1][OUT_W-1:0];
      res_data_next.force_z     = fo[2][OUT_W-1:0];
      res_data_next.pair_energy = m7_side.want_e ? eo[OUT_W-1:0] : '0;
      res_data_next.status      = sat_all ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= m7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= res_data_next;
    end
  end

  // Checks
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_ZERO) |->
      (res_data.force_x == '0) && (res_data.force_y == '0) &&
      (res_data.force_z == '0) && (res_data.pair_energy == '0))
    else $error("zero-distance result carries non-zero outputs");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.status == ST_OK) || (res_data.status == ST_SAT) ||
                  (res_data.status == ST_ZERO))
    else $error("undefined status code");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> res_valid && res_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !res_valid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire
